>>> src/nwsa_pkg.sv
package nwsa_pkg;

  localparam int IdxW      = 6;
  localparam int AccW      = 40;
  localparam int FracW     = 12;
  localparam int TabW      = 16;
  localparam int TabN      = 256;
  localparam int FifoDepth = 8;
  localparam int FifoPtrW  = 3;
  localparam int FifoCntW  = 4;
  localparam int CfgIdxW   = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegMode = 1'd0;
  localparam logic [CfgIdxW-1:0] RegBias = 1'd1;

  // Item kinds carried in tuser.
  localparam logic ActWeight = 1'b0;
  localparam logic ActInput  = 1'b1;

  // Activation modes.
  localparam logic [2:0] ModeLogistic = 3'd0;
  localparam logic [2:0] ModeTanh     = 3'd1;
  localparam logic [2:0] ModeSoftplus = 3'd2;
  localparam logic [2:0] ModeRelu     = 3'd3;
  localparam logic [2:0] ModeLeaky    = 3'd4;

  typedef logic signed [TabW-1:0] tab_t [TabN];

  // Unsigned quotient by restoring shift and subtract; only evaluated while the
  // tables are built, so it costs no logic.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned dvs);
    longint unsigned quo;
    longint unsigned rem;
    int              b;
    quo = 64'd0;
    rem = 64'd0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= dvs) begin
        rem    = rem - dvs;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Builds one activation table at elaboration. Entry i holds f(x) in Q4.12 at
  // x = (i - 128) / 16. The powers of exp(-1/16) are kept in Q30, and ln(1+u) is
  // taken from an atanh series.
  function automatic tab_t build_tab(input logic [2:0] kind);
    longint unsigned en [257];
    longint          term;
    longint          acc;
    longint unsigned one_q30;
    longint unsigned d;
    longint unsigned m;
    longint unsigned q;
    longint unsigned den;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned lg;
    longint unsigned th;
    longint unsigned sp;
    longint          val;
    int              n;
    int              i;
    int              k;
    int              a;
    tab_t            tab;
    one_q30 = 64'd1 << 30;
    term = longint'(64'd1 << 40);
    acc  = term;
    for (n = 1; n <= 14; n++) begin
      term = longint'(udiv(64'(term), 64'(16 * n)));
      if ((n & 1) == 1) acc = acc - term;
      else              acc = acc + term;
    end
    d = (longint'(acc) + 64'd512) >> 10;
    en[0] = one_q30;
    for (i = 1; i <= 256; i++) begin
      en[i] = (en[i-1] * d + (64'd1 << 29)) >> 30;
    end
    for (i = 0; i < TabN; i++) begin
      k = i - 128;
      a = (k < 0) ? -k : k;
      m = en[a];
      q = en[2*a];
      lg = udiv((64'd1 << 42) + ((one_q30 + m) >> 1), one_q30 + m);
      th = udiv((one_q30 - q) * 64'd4096 + ((one_q30 + q) >> 1), one_q30 + q);
      den = (64'd1 << 31) + m;
      z   = udiv((m << 30) + (den >> 1), den);
      z2  = (z * z + (64'd1 << 29)) >> 30;
      t   = z;
      s   = 64'd0;
      for (n = 0; n < 20; n++) begin
        s = s + udiv(t, 64'(2 * n + 1));
        t = (t * z2) >> 30;
      end
      sp = (64'd2 * s + (64'd1 << 17)) >> 18;
      case (kind)
        ModeLogistic: val = (k >= 0) ? longint'(lg) : 64'sd4096 - longint'(lg);
        ModeTanh:     val = (k >= 0) ? longint'(th) : -longint'(th);
        default:      val = (k >= 0) ? longint'(k * 256) + longint'(sp) : longint'(sp);
      endcase
      tab[i] = TabW'(val);
    end
    return tab;
  endfunction

  localparam tab_t LogisticTab = build_tab(ModeLogistic);
  localparam tab_t TanhTab     = build_tab(ModeTanh);
  localparam tab_t SoftplusTab = build_tab(ModeSoftplus);

endpackage

>>> src/nwsa_ram.sv
module nwsa_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [Width-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [Width-1:0] rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/neuron_weighted_sum_activation.sv
// One neuron's forward pass. A transaction with tuser 0 writes a weight into the
// weight RAM; with tuser 1 it presents an input element, which is multiplied by the
// stored weight at its index and added into a saturating 40-bit accumulator. The
// element marked with tlast closes the vector: the bias is added, the selected
// activation is applied, and one result leaves on the master side. One transaction
// is accepted in every cycle while s_tready is high; the weight RAM has one write
// and one read port, and each transaction uses one of them once, so nothing in the
// datapath holds the rate below that. Up to eight results can wait in the output
// queue; s_tready falls only while eight results are owed. Weights read before they
// were written are undefined, so there is no clearing pass after reset. The user
// must write configuration only while the block idles; the block does not check it.
module neuron_weighted_sum_activation #(
  parameter int MAX_INPUTS = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // element_index, then data_value, zero padding on top
  input  logic [((nwsa_pkg::IdxW + DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // action
  input  logic s_tuser,
  // last_element
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // activation_value, then weighted_sum, zero padding on top
  output logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [nwsa_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data
);

  import nwsa_pkg::*;

  localparam int OutW  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int AddrW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int ProdW = 2 * DATA_WIDTH;
  localparam int SumW  = ((AccW > ProdW) ? AccW : ProdW) + 1;
  localparam int SW    = ((AccW > DATA_WIDTH + FracW) ? AccW : DATA_WIDTH + FracW) + 1;
  localparam int QW    = SW - FracW;
  localparam int XW    = QW + 1;
  localparam int RK    = XW + 4;
  localparam int RW    = RK - 3;

  // Reciprocal of 11 scaled by 2**RK, rounded up; exact floor for inputs below 2**XW.
  localparam logic [RW-1:0] Recip = RW'(((64'd1 << RK) / 64'd11) + 64'd1);

  localparam logic signed [SumW-1:0] AccHi =
    {{(SumW - AccW + 1){1'b0}}, {(AccW - 1){1'b1}}};
  localparam logic signed [SumW-1:0] AccLo = ~AccHi;
  localparam logic signed [QW-1:0] DataHi =
    {{(QW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [QW-1:0] DataLo = ~DataHi;
  localparam logic signed [QW-1:0] ClipHi =
    {{(QW - TabW + 1){1'b0}}, {(TabW - 1){1'b1}}};
  localparam logic signed [QW-1:0] ClipLo = ~ClipHi;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] ws;
    logic signed [DATA_WIDTH-1:0] act;
  } res_t;

  function automatic logic signed [DATA_WIDTH-1:0] sat_q(input logic signed [QW-1:0] v);
    logic signed [DATA_WIDTH-1:0] r;
    if (v > DataHi)      r = DataHi[DATA_WIDTH-1:0];
    else if (v < DataLo) r = DataLo[DATA_WIDTH-1:0];
    else                 r = v[DATA_WIDTH-1:0];
    return r;
  endfunction

  // Configuration registers
  logic [2:0]                   act_mode;
  logic signed [DATA_WIDTH-1:0] bias;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_mode <= ModeTanh;
      bias     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegMode: act_mode <= cfg_data[2:0];
        RegBias: bias     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input side and weight RAM
  logic                         in_fire;
  logic                         res_req;
  logic [IdxW-1:0]              in_idx;
  logic signed [DATA_WIDTH-1:0] in_data;
  logic                         in_ok;
  logic [AddrW-1:0]             ram_addr;
  logic                         ram_wr;
  logic                         ram_rd;
  logic signed [DATA_WIDTH-1:0] weight_rd;
  logic [FifoCntW-1:0]          pending;

  assign s_tready = pending < FifoCntW'(FifoDepth);
  assign in_fire  = s_tvalid && s_tready;
  assign in_idx   = s_tdata[IdxW-1:0];
  assign in_data  = s_tdata[IdxW +: DATA_WIDTH];
  assign in_ok    = int'(in_idx) < MAX_INPUTS;
  assign ram_addr = AddrW'(in_idx);
  assign ram_wr   = in_fire && (s_tuser == ActWeight) && in_ok;
  assign ram_rd   = in_fire && (s_tuser == ActInput);
  assign res_req  = ram_rd && s_tlast;

  nwsa_ram #(
    .Width (DATA_WIDTH),
    .Depth (MAX_INPUTS)
  ) u_weights (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (ram_addr),
    .wr_data (in_data),
    .rd_en   (ram_rd),
    .rd_addr (ram_addr),
    .rd_data (weight_rd)
  );

  // Pipeline registers
  logic                         a_vld;
  logic                         a_last;
  logic                         a_ok;
  logic signed [DATA_WIDTH-1:0] a_data;
  logic                         b_vld;
  logic                         b_last;
  logic signed [ProdW-1:0]      b_prod;
  logic signed [AccW-1:0]       acc;
  logic                         c_vld;
  logic signed [AccW-1:0]       c_acc;
  logic                         d_vld;
  logic signed [QW-1:0]         d_q;
  logic                         e_vld;
  logic                         e_neg;
  logic signed [TabW-1:0]       e_tab;
  logic signed [DATA_WIDTH-1:0] e_qsat;
  logic [XW+RW-1:0]             e_lprod;

  // Combinational values between the stages
  logic signed [ProdW-1:0]      mul;
  logic signed [SumW-1:0]       acc_sum;
  logic signed [AccW-1:0]       acc_next;
  logic signed [SW-1:0]         s_sum;
  logic [QW-1:0]                q_mag;
  logic [XW-1:0]                q_twice;
  logic signed [TabW-1:0]       q_clip;
  logic [7:0]                   tab_idx;
  logic signed [TabW-1:0]       tab_val;
  logic [XW-4:0]                quot;
  logic signed [QW-1:0]         leaky_neg;
  logic signed [DATA_WIDTH-1:0] act_val;
  res_t                         res_next;

  assign mul = weight_rd * a_data;

  always_comb begin
    acc_sum = SumW'(acc) + SumW'(b_prod);
    if (acc_sum > AccHi)      acc_next = AccHi[AccW-1:0];
    else if (acc_sum < AccLo) acc_next = AccLo[AccW-1:0];
    else                      acc_next = acc_sum[AccW-1:0];
  end

  // The arithmetic shift is the floor of the Q17.24 sum in Q17.12.
  assign s_sum = SW'(c_acc) + (SW'(bias) <<< FracW);

  always_comb begin
    q_mag   = d_q[QW-1] ? QW'(-d_q) : QW'(d_q);
    q_twice = {q_mag, 1'b0};
    if (d_q > ClipHi)      q_clip = ClipHi[TabW-1:0];
    else if (d_q < ClipLo) q_clip = ClipLo[TabW-1:0];
    else                   q_clip = d_q[TabW-1:0];
    // Offsetting by 8.0 and dropping eight bits gives the bin of 1/16.
    tab_idx = {~q_clip[TabW-1], q_clip[TabW-2:TabW-8]};
    case (act_mode)
      ModeLogistic: tab_val = LogisticTab[tab_idx];
      ModeTanh:     tab_val = TanhTab[tab_idx];
      default:      tab_val = SoftplusTab[tab_idx];
    endcase
  end

  always_comb begin
    quot      = e_lprod[XW+RW-1:RK];
    leaky_neg = -QW'(signed'({1'b0, quot}));
    case (act_mode)
      ModeLogistic, ModeTanh, ModeSoftplus: act_val = sat_q(QW'(e_tab));
      ModeRelu:  act_val = e_neg ? '0 : e_qsat;
      ModeLeaky: act_val = e_neg ? sat_q(leaky_neg) : e_qsat;
      default:   act_val = '0;
    endcase
    res_next.ws  = e_qsat;
    res_next.act = act_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      c_vld <= 1'b0;
      d_vld <= 1'b0;
      e_vld <= 1'b0;
      acc   <= '0;
    end else begin
      a_vld <= ram_rd;
      b_vld <= a_vld;
      c_vld <= b_vld && b_last;
      d_vld <= c_vld;
      e_vld <= d_vld;
      if (b_vld) begin
        acc <= b_last ? '0 : acc_next;
      end
    end
    a_last  <= s_tlast;
    a_ok    <= in_ok;
    a_data  <= in_data;
    b_last  <= a_last;
    b_prod  <= a_ok ? mul : '0;
    c_acc   <= acc_next;
    d_q     <= QW'(s_sum >>> FracW);
    e_neg   <= d_q[QW-1];
    e_tab   <= tab_val;
    e_qsat  <= sat_q(d_q);
    e_lprod <= q_twice * Recip;
  end

  // Output queue; pending counts results owed, queued or still in the pipeline.
  res_t                fifo_mem [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr;
  logic [FifoPtrW-1:0] rd_ptr;
  logic [FifoCntW-1:0] fifo_cnt;
  logic                out_fire;

  assign m_tvalid = fifo_cnt != '0;
  assign out_fire = m_tvalid && m_tready;
  assign m_tdata  = OutW'(fifo_mem[rd_ptr]);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      pending  <= '0;
    end else begin
      if (e_vld) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_cnt <= fifo_cnt + FifoCntW'(e_vld) - FifoCntW'(out_fire);
      pending  <= pending + FifoCntW'(res_req) - FifoCntW'(out_fire);
    end
    if (e_vld) begin
      fifo_mem[wr_ptr] <= res_next;
    end
  end

  a_queue_within_owed: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= pending)
    else $error("output queue holds more results than are owed");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    e_vld |-> fifo_cnt < FifoCntW'(FifoDepth))
    else $error("result pushed into a full output queue");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    (b_vld && b_last) |=> (acc == '0))
    else $error("accumulator not cleared after the last element");

endmodule

>>> dv/neuron_output_checker.sv
module neuron_output_checker (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  // element_index, then data_value, zero padding on top
  input  logic [23:0] s_tdata,
  // action
  input  logic s_tuser,
  // last_element
  input  logic s_tlast,
  input  logic m_tvalid,
  input  logic m_tready,
  // activation_value, then weighted_sum
  input  logic [31:0] m_tdata,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [nwsa_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output int errors,
  output int pending
);

  import nwsa_pkg::*;

  localparam longint AccMax = (64'sd1 <<< 39) - 64'sd1;
  localparam longint AccMin = -AccMax - 64'sd1;

  typedef struct packed {
    logic signed [15:0] wsum;
    logic signed [15:0] act;
  } neuron_out_t;

  int                 logistic_lut [256];
  int                 tanh_lut [256];
  int                 softplus_lut [256];
  logic signed [15:0] weight_mem [64];
  longint             acc_q24;
  logic [2:0]         act_mode;
  logic signed [15:0] bias_q12;
  neuron_out_t        owed_outputs [$];

  function automatic logic signed [15:0] sat_q12(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  // Activation tables sampled at the lower edge of each 1/16 bin over [-8, 8).
  // Powers of exp(-1/16) are carried in Q30; ln(1+u) comes from an atanh series.
  initial begin : build_luts
    longint          term;
    longint          series;
    longint unsigned one_q30;
    longint unsigned step_q30;
    longint unsigned e_pow [257];
    longint unsigned mq;
    longint unsigned qq;
    longint unsigned den;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned t;
    longint unsigned s_sum;
    int              k;
    int              a;
    int              lg;
    int              th;
    int              sp;
    one_q30 = 64'd1 << 30;
    term = 64'sd1 <<< 40;
    series = term;
    for (int n = 1; n <= 14; n++) begin
      term = term / (16 * n);
      series = (n % 2 == 1) ? series - term : series + term;
    end
    step_q30 = longint'(series + 64'sd512) >> 10;
    e_pow[0] = one_q30;
    for (int i = 1; i <= 256; i++) begin
      e_pow[i] = (e_pow[i-1] * step_q30 + (64'd1 << 29)) >> 30;
    end
    for (int i = 0; i < 256; i++) begin
      k = i - 128;
      a = (k < 0) ? -k : k;
      mq = e_pow[a];
      qq = e_pow[2*a];
      lg = int'(((64'd1 << 42) + (one_q30 + mq) / 64'd2) / (one_q30 + mq));
      th = int'(((one_q30 - qq) * 64'd4096 + (one_q30 + qq) / 64'd2) / (one_q30 + qq));
      den = (64'd1 << 31) + mq;
      z = ((mq << 30) + den / 64'd2) / den;
      z2 = (z * z + (64'd1 << 29)) >> 30;
      t = z;
      s_sum = 64'd0;
      for (int n = 0; n < 20; n++) begin
        s_sum = s_sum + t / longint'(2 * n + 1);
        t = (t * z2) >> 30;
      end
      sp = int'((64'd2 * s_sum + (64'd1 << 17)) >> 18);
      logistic_lut[i] = (k >= 0) ? lg : 4096 - lg;
      tanh_lut[i]     = (k >= 0) ? th : -th;
      softplus_lut[i] = (k >= 0) ? k * 256 + sp : sp;
    end
  end

  always @(posedge clk) begin : track
    longint             total;
    longint             q;
    longint             c;
    longint             act;
    int                 ti;
    logic [5:0]         idx;
    logic signed [15:0] dval;
    neuron_out_t        got;
    neuron_out_t        want;
    if (rst) begin
      acc_q24 = 0;
      act_mode = ModeTanh;
      bias_q12 = 16'sd0;
      owed_outputs.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (owed_outputs.size() == 0) begin
          errors++;
          $display("%0t: expected no result, got activation_value %0d weighted_sum %0d",
                   $time, got.act, got.wsum);
        end else begin
          want = owed_outputs.pop_front();
          if (got.act !== want.act) begin
            errors++;
            $display("%0t: activation_value expected %0d, got %0d",
                     $time, want.act, got.act);
          end
          if (got.wsum !== want.wsum) begin
            errors++;
            $display("%0t: weighted_sum expected %0d, got %0d",
                     $time, want.wsum, got.wsum);
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegMode: act_mode = cfg_data[2:0];
          RegBias: bias_q12 = cfg_data;
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        idx = s_tdata[5:0];
        dval = s_tdata[21:6];
        if (s_tuser == ActWeight) begin
          weight_mem[idx] = dval;
        end else begin
          acc_q24 = acc_q24 + longint'(weight_mem[idx]) * longint'(dval);
          if (acc_q24 > AccMax) acc_q24 = AccMax;
          if (acc_q24 < AccMin) acc_q24 = AccMin;
          if (s_tlast) begin
            total = acc_q24 + longint'(bias_q12) * 4096;
            acc_q24 = 0;
            // Arithmetic shift floors toward minus infinity.
            q = total >>> 12;
            c = (q > 32767) ? 32767 : ((q < -32768) ? -32768 : q);
            ti = int'((c + 32768) >>> 8);
            case (act_mode)
              ModeLogistic: act = logistic_lut[ti];
              ModeTanh:     act = tanh_lut[ti];
              ModeSoftplus: act = softplus_lut[ti];
              ModeRelu:     act = (q <= 0) ? 0 : q;
              ModeLeaky:    act = (q < 0) ? (2 * q) / 11 : q;
              default:      act = 0;
            endcase
            want.act = sat_q12(act);
            want.wsum = sat_q12(q);
            owed_outputs.push_back(want);
          end
        end
      end
      pending = owed_outputs.size();
    end
  end

endmodule

>>> dv/testbench.sv
module testbench;

  import nwsa_pkg::*;

  localparam logic [2:0] ModeSpareLow  = 3'd5;
  localparam logic [2:0] ModeSpareHigh = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [23:0]         s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [31:0]         m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [15:0]         cfg_data = '0;
  int                  check_errors;
  int                  owed_count;
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;

  always #4 clk = ~clk;

  neuron_weighted_sum_activation dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  neuron_output_checker u_check (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors(check_errors),
    .pending(owed_count)
  );

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #(8 * 400000);
    $display("testbench failed");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_item(input logic act, input logic [5:0] idx,
                           input logic [15:0] val, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {2'b00, val, idx};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers change only once all results are out and the pipeline has drained.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    s_tvalid <= 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'($urandom);
      5, 6, 7: return 16'($urandom_range(8192) - 4096);
      default: return 16'($urandom_range(2048) - 1024);
    endcase
  endfunction

  task automatic run_random(input int n_items);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        len = $urandom_range(1, 4);
        repeat (len) push_item(ActWeight, 6'($urandom), pick_value(), 1'($urandom));
      end else begin
        len = ($urandom_range(15) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 6);
        // An unterminated run carries its sum into the next vector.
        for (int j = 0; j < len; j++)
          push_item(ActInput, 6'($urandom), pick_value(), (pick != 1) && (j == len - 1));
      end
      sent += len;
    end
  endtask

  initial begin
    logic [2:0]  mode_sel;
    logic [15:0] bias_sel;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset configuration.
    push_item(ActWeight, 6'd0, 16'h7FFF, 1'b0);
    push_item(ActWeight, 6'd1, 16'h8000, 1'b1);  // a weight marked last gives no result
    push_item(ActWeight, 6'd2, 16'h1000, 1'b0);
    push_item(ActWeight, 6'd63, 16'hFFFF, 1'b0);
    push_item(ActWeight, 6'd32, 16'h0000, 1'b0);
    push_item(ActInput, 6'd2, 16'h1000, 1'b1);
    push_item(ActInput, 6'd0, 16'h7FFF, 1'b0);
    push_item(ActInput, 6'd0, 16'h7FFF, 1'b1);
    push_item(ActInput, 6'd1, 16'h7FFF, 1'b0);
    push_item(ActInput, 6'd1, 16'h7FFF, 1'b1);
    push_item(ActInput, 6'd1, 16'h8000, 1'b1);
    push_item(ActInput, 6'd63, 16'h8000, 1'b1);
    push_item(ActInput, 6'd63, 16'h0001, 1'b1);  // tiny negative sum floors to -1
    push_item(ActInput, 6'd32, 16'h7FFF, 1'b1);
    push_item(ActInput, 6'd2, 16'h8000, 1'b1);
    push_item(ActInput, 6'd2, 16'h7FFF, 1'b1);

    // Drive the accumulator into its positive bound, then pull back a little:
    // a clamped sum stays near the top, a wrapped one would go negative.
    repeat (520) push_item(ActInput, 6'd1, 16'h8000, 1'b0);
    push_item(ActInput, 6'd1, 16'h7FFF, 1'b0);
    push_item(ActInput, 6'd1, 16'h7FFF, 1'b0);
    push_item(ActInput, 6'd1, 16'h7FFF, 1'b1);

    for (int i = 0; i < 64; i++) push_item(ActWeight, 6'(i), pick_value(), 1'($urandom));

    for (int k = 0; k < 12; k++) begin
      case (k % 6)
        0:       mode_sel = ModeLogistic;
        1:       mode_sel = ModeTanh;
        2:       mode_sel = ModeSoftplus;
        3:       mode_sel = ModeRelu;
        4:       mode_sel = ModeLeaky;
        default: mode_sel = (k < 6) ? ModeSpareLow : ModeSpareHigh;
      endcase
      if (k == 1)                bias_sel = 16'h7FFF;
      else if (k == 2)           bias_sel = 16'h8000;
      else if (k == 0 || k == 6) bias_sel = 16'h0000;
      else                       bias_sel = pick_value();
      write_reg(RegMode, {13'd0, mode_sel});
      write_reg(RegBias, bias_sel);
      case (k % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      run_random(27);
    end

    s_tvalid <= 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (check_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/nwsa_pkg.sv
src/nwsa_ram.sv
src/neuron_weighted_sum_activation.sv
dv/neuron_output_checker.sv
dv/testbench.sv
